FILE: hw/rtl/mlp_5_8_1_inference_macros.svh
// Assertion macros for the mlp_5_8_1_inference block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef MLP_5_8_1_INFERENCE_MACROS_SVH
`define MLP_5_8_1_INFERENCE_MACROS_SVH
// same-cycle implication
`define MLP581_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define MLP581_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: hw/rtl/mlp581_pkg.sv
// Shared types and constants of the 5-8-1 network block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package mlp581_pkg;
	localparam int FEAT_N = 5;
	localparam int DATA_W = 16;
	localparam int IDX_W  = 6;
	localparam int ACC_W  = 36;
	localparam int TERM_W = 5;
	localparam int SEL_W  = 4;
	localparam int TAB_W  = 12;
	localparam int DIFF_W = 10;
	localparam int FRAC_W = 10;

	localparam logic signed [DATA_W-1:0] ONE_Q12 = 16'sd4096;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	// round(4096*tanh(k/4)), k = 0..16
	localparam logic [TAB_W-1:0] TANH_TAB [17] = '{
		12'd0, 12'd1003, 12'd1893, 12'd2602, 12'd3119, 12'd3475, 12'd3707, 12'd3856,
		12'd3949, 12'd4006, 12'd4041, 12'd4062, 12'd4076, 12'd4084, 12'd4089,
		12'd4091, 12'd4093
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_SAT,
		ST_TMUL,
		ST_TFIN
	} state_t;

	typedef struct packed {
		logic             issue;
		logic             first;
		logic             bias;
		logic             hid;
		logic [SEL_W-1:0] sel;
		logic             sat;
		logic             tanh_mul;
		logic             fin;
		logic             out_layer;
	} ctl_t;
endpackage

FILE: hw/rtl/mlp_5_8_1_inference.sv
// Load: one weight per cycle while idle, no result. Evaluate: busy until the result
// is made; done pulses for one cycle as busy falls. Evaluations do not overlap.
// The work runs on one shared 16x16 multiplier taking one weight per cycle from the
// single-read weight store, plus drain and three tanh steps per unit.
// Reset clears control only; weights stay undefined until loaded. Results cannot stall.
`timescale 1ns / 1ps
`include "mlp_5_8_1_inference_macros.svh"
module mlp_5_8_1_inference
	import mlp581_pkg::*;
#(
	parameter int HIDDEN_UNITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     op,
	input  logic [IDX_W-1:0]         weight_index,
	input  logic signed [DATA_W-1:0] weight_value,
	input  logic signed [DATA_W-1:0] feature_0,
	input  logic signed [DATA_W-1:0] feature_1,
	input  logic signed [DATA_W-1:0] feature_2,
	input  logic signed [DATA_W-1:0] feature_3,
	input  logic signed [DATA_W-1:0] feature_4,
	output logic                     busy,
	output logic                     done,
	output logic [DATA_W-1:0]        activation
);
	localparam int WC     = HIDDEN_UNITS * (FEAT_N + 1) + HIDDEN_UNITS + 1;
	localparam int AW     = $clog2(WC);
	localparam int UNIT_W = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
	localparam int IX_W   = (AW > IDX_W) ? AW : IDX_W;

	logic                     accept;
	logic                     go;
	logic                     we;
	logic [IX_W-1:0]          idx_ext;
	logic [AW-1:0]            raddr;
	logic signed [DATA_W-1:0] rdata;
	logic [UNIT_W-1:0]        unit;
	ctl_t                     ctl;
	logic                     s1_valid;
	logic signed [ACC_W-1:0]  acc;
	logic signed [31:0]       prod;
	logic [DIFF_W-1:0]        diff;
	logic [FRAC_W-1:0]        frac;
	logic signed [DATA_W-1:0] tanh_val;
	logic signed [DATA_W-1:0] feat [FEAT_N];
	logic signed [16:0]       act_sum;
	logic                     done_q;
	logic [DATA_W-1:0]        act_q;

	assign accept  = start && !busy;
	assign go      = accept && (op == OP_EVAL);
	assign idx_ext = IX_W'(weight_index);
	assign we      = accept && (op == OP_LOAD) && ({1'b0, idx_ext} < (IX_W+1)'(WC));

	assign feat[0] = feature_0;
	assign feat[1] = feature_1;
	assign feat[2] = feature_2;
	assign feat[3] = feature_3;
	assign feat[4] = feature_4;

	mlp581_wmem #(
		.DEPTH(WC),
		.AW   (AW)
	) u_wmem (
		.clk  (clk),
		.we   (we),
		.waddr(idx_ext[AW-1:0]),
		.wdata(weight_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	mlp581_seq #(
		.HIDDEN_UNITS(HIDDEN_UNITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.s1_valid(s1_valid),
		.busy    (busy),
		.raddr   (raddr),
		.unit    (unit),
		.ctl     (ctl)
	);

	mlp581_mac #(
		.HIDDEN_UNITS(HIDDEN_UNITS)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.feat_load(go),
		.feat     (feat),
		.rdata    (rdata),
		.diff     (diff),
		.frac     (frac),
		.unit     (unit),
		.tanh_val (tanh_val),
		.s1_valid (s1_valid),
		.acc      (acc),
		.prod     (prod)
	);

	mlp581_act u_act (
		.clk     (clk),
		.ctl     (ctl),
		.acc     (acc),
		.prod    (prod),
		.diff    (diff),
		.frac    (frac),
		.tanh_val(tanh_val)
	);

	// 0.5 + tanh(x/2)/2 in Q0.16
	assign act_sum = 17'sd32768 + (17'(tanh_val) <<< 3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.fin && ctl.out_layer;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin && ctl.out_layer) begin
			act_q <= act_sum[DATA_W-1:0];
		end
	end

	assign done       = done_q;
	assign activation = act_q;

	`MLP581_ASSERT_NOW(a_done_idle, done, !busy, "result transfer while busy")
	`MLP581_ASSERT_NEXT(a_eval_busy, start && !busy && op == OP_EVAL, busy, "evaluate did not start")
	`MLP581_ASSERT_NEXT(a_load_free, start && !busy && op == OP_LOAD, !busy, "load made the block busy")
	`MLP581_ASSERT_NOW(a_act_range, done, activation >= 16'd24 && activation <= 16'd65512, "activation out of range")
endmodule

FILE: hw/rtl/mlp581_wmem.sv
// Weight store: one write port, one registered read port.
// Depends on mlp581_pkg.
`timescale 1ns / 1ps
module mlp581_wmem
	import mlp581_pkg::*;
#(
	parameter int DEPTH = 57,
	parameter int AW    = 6
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic signed [DATA_W-1:0] wdata,
	input  logic [AW-1:0]            raddr,
	output logic signed [DATA_W-1:0] rdata
);
	logic signed [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule

FILE: hw/rtl/mlp581_act.sv
// Saturating rescale and piecewise-linear tanh around the shared multiplier.
// Depends on mlp581_pkg.
`timescale 1ns / 1ps
module mlp581_act
	import mlp581_pkg::*;
(
	input  logic                     clk,
	input  ctl_t                     ctl,
	input  logic signed [ACC_W-1:0]  acc,
	input  logic signed [31:0]       prod,
	output logic [DIFF_W-1:0]        diff,
	output logic [FRAC_W-1:0]        frac,
	output logic signed [DATA_W-1:0] tanh_val
);
	logic signed [ACC_W-1:0]  shifted;
	logic signed [DATA_W-1:0] x_sat;
	logic signed [16:0]       x_ext;
	logic [16:0]              mag;
	logic                     big;
	logic [4:0]               lo_idx;
	logic [TAB_W-1:0]         base;
	logic [TAB_W-1:0]         nxt;
	logic [TAB_W-1:0]         base_q;
	logic                     neg_q;
	logic [TAB_W:0]           t_mag;

	always_comb begin
		shifted = ctl.out_layer ? (acc >>> 13) : (acc >>> 12);
		if (shifted > ACC_W'(32767)) begin
			x_sat = 16'sh7fff;
		end else if (shifted < -ACC_W'(32768)) begin
			x_sat = -16'sh8000;
		end else begin
			x_sat = shifted[DATA_W-1:0];
		end
		x_ext  = 17'(x_sat);
		mag    = (x_ext < 0) ? 17'(-x_ext) : 17'(x_ext);
		big    = (mag[16:14] != 3'd0);
		lo_idx = {1'b0, mag[13:10]};
		base   = big ? TANH_TAB[16] : TANH_TAB[lo_idx];
		nxt    = TANH_TAB[lo_idx + 5'd1];
	end

	always_ff @(posedge clk) begin
		if (ctl.sat) begin
			neg_q  <= x_sat[DATA_W-1];
			base_q <= base;
			diff   <= big ? '0 : DIFF_W'(nxt - base);
			frac   <= mag[FRAC_W-1:0];
		end
	end

	always_comb begin
		t_mag    = {1'b0, base_q} + (TAB_W+1)'(prod[19:10]);
		tanh_val = neg_q ? -DATA_W'(t_mag) : DATA_W'(t_mag);
	end
endmodule

FILE: hw/rtl/mlp581_mac.sv
// Shared multiply-accumulate unit with operand registers (features, hidden values).
// Depends on mlp581_pkg; fed by mlp581_wmem read data and mlp581_act.
`timescale 1ns / 1ps
module mlp581_mac
	import mlp581_pkg::*;
#(
	parameter int HIDDEN_UNITS = 8,
	localparam int UNIT_W = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctl_t                     ctl,
	input  logic                     feat_load,
	input  logic signed [DATA_W-1:0] feat [FEAT_N],
	input  logic signed [DATA_W-1:0] rdata,
	input  logic [DIFF_W-1:0]        diff,
	input  logic [FRAC_W-1:0]        frac,
	input  logic [UNIT_W-1:0]        unit,
	input  logic signed [DATA_W-1:0] tanh_val,
	output logic                     s1_valid,
	output logic signed [ACC_W-1:0]  acc,
	output logic signed [31:0]       prod
);
	logic signed [DATA_W-1:0] feat_q [FEAT_N];
	logic signed [DATA_W-1:0] hid_q [HIDDEN_UNITS];
	logic                     v_s1;
	logic                     first_s1;
	logic                     bias_s1;
	logic                     hid_s1;
	logic [SEL_W-1:0]         sel_s1;
	logic                     v_s2;
	logic                     first_s2;
	logic signed [31:0]       prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DATA_W-1:0] opnd;
	logic signed [DATA_W-1:0] mul_a;
	logic signed [DATA_W-1:0] mul_b;

	always_ff @(posedge clk) begin
		if (feat_load) begin
			for (int j = 0; j < FEAT_N; j++) begin
				feat_q[j] <= feat[j];
			end
		end
		if (ctl.fin && !ctl.out_layer) begin
			hid_q[unit] <= tanh_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= ctl.first;
		bias_s1  <= ctl.bias;
		hid_s1   <= ctl.hid;
		sel_s1   <= ctl.sel;
		first_s2 <= first_s1;
	end

	always_comb begin
		if (bias_s1) begin
			opnd = ONE_Q12;
		end else if (hid_s1) begin
			opnd = hid_q[sel_s1[UNIT_W-1:0]];
		end else begin
			opnd = feat_q[sel_s1[2:0]];
		end
		mul_a = ctl.tanh_mul ? DATA_W'(diff) : opnd;
		mul_b = ctl.tanh_mul ? DATA_W'(frac) : rdata;
	end

	always_ff @(posedge clk) begin
		if (v_s1 || ctl.tanh_mul) begin
			prod_s2 <= mul_a * mul_b;
		end
		if (v_s2) begin
			acc_q <= first_s2 ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
	end

	assign s1_valid = v_s1;
	assign acc      = acc_q;
	assign prod     = prod_s2;
endmodule

FILE: hw/rtl/mlp581_seq.sv
// Sequencer: walks the packed weights, units and activation steps.
// Depends on mlp581_pkg; drives mlp581_wmem, mlp581_mac and mlp581_act.
`timescale 1ns / 1ps
module mlp581_seq
	import mlp581_pkg::*;
#(
	parameter int HIDDEN_UNITS = 8,
	localparam int WC     = HIDDEN_UNITS * (FEAT_N + 1) + HIDDEN_UNITS + 1,
	localparam int AW     = $clog2(WC),
	localparam int UNIT_W = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic              s1_valid,
	output logic              busy,
	output logic [AW-1:0]     raddr,
	output logic [UNIT_W-1:0] unit,
	output ctl_t              ctl
);
	state_t              state_q;
	state_t              state_d;
	logic [AW-1:0]       wptr_q;
	logic [TERM_W-1:0]   term_q;
	logic [UNIT_W-1:0]   unit_q;
	logic                out_q;
	logic [TERM_W-1:0]   last_term;
	logic                last_unit;

	assign last_term = out_q ? TERM_W'(HIDDEN_UNITS) : TERM_W'(FEAT_N);
	assign last_unit = (unit_q == UNIT_W'(HIDDEN_UNITS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (go) state_d = ST_MAC;
			ST_MAC:   if (term_q == last_term) state_d = ST_DRAIN;
			ST_DRAIN: if (!s1_valid) state_d = ST_SAT;
			ST_SAT:   state_d = ST_TMUL;
			ST_TMUL:  state_d = ST_TFIN;
			ST_TFIN:  state_d = out_q ? ST_IDLE : ST_MAC;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl           = '0;
		ctl.first     = (term_q == '0);
		ctl.bias      = (term_q == last_term);
		ctl.hid       = out_q;
		ctl.sel       = term_q[SEL_W-1:0];
		ctl.out_layer = out_q;
		unique case (state_q)
			ST_MAC:  ctl.issue    = 1'b1;
			ST_SAT:  ctl.sat      = 1'b1;
			ST_TMUL: ctl.tanh_mul = 1'b1;
			ST_TFIN: ctl.fin      = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wptr_q  <= '0;
			term_q  <= '0;
			unit_q  <= '0;
			out_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				wptr_q <= '0;
				term_q <= '0;
				unit_q <= '0;
				out_q  <= 1'b0;
			end else if (state_q == ST_MAC) begin
				wptr_q <= wptr_q + 1'b1;
				term_q <= (term_q == last_term) ? '0 : term_q + 1'b1;
			end else if (state_q == ST_TFIN && !out_q) begin
				if (last_unit) begin
					out_q <= 1'b1;
				end else begin
					unit_q <= unit_q + 1'b1;
				end
			end
		end
	end

	assign busy  = (state_q != ST_IDLE);
	assign raddr = wptr_q;
	assign unit  = unit_q;
endmodule
